>>> src/oli_pkg.sv
// Shared types and codes for the ordered list block.
package oli_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT,
		CMD_PUSH_BACK,
		CMD_DELETE,
		CMD_DUMP
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_NOT_FOUND,
		ST_EMPTY
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;      // latch the key and restart the scan
		logic    wr_front;  // insert the input value at the front
		logic    wr_back;   // insert the input value at the back
		logic    rd;        // issue a read at the scan index
		logic    step;      // process the word returned by the last read
		logic    commit;    // a match was removed: drop one entry
		logic    emit;      // load the result registers
		status_t status;
		logic    item_sel;  // result item comes from the read data
		logic    last;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic issue_done;  // every live entry has been read
		logic pv;          // read data is fresh
		logic plast;       // fresh read data is the back entry
		logic found;       // a match has been seen, this word included
	} sts_t;

endpackage

>>> src/oli_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module oli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/oli_ctrl.sv
// Controller state machine for the ordered list block.
module oli_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  oli_pkg::cmd_t  cmd,
	input  oli_pkg::sts_t  sts,
	output oli_pkg::ctl_t  ctl,
	output logic           busy,
	output logic           result_valid
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEL,
		S_DUMP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		ctl      = '0;
		ctl.status = oli_pkg::ST_OK;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						oli_pkg::CMD_PUSH_FRONT, oli_pkg::CMD_PUSH_BACK: begin
							ctl.emit = 1'b1;
							ctl.last = 1'b1;
							if (sts.full) begin
								ctl.status = oli_pkg::ST_FULL;
							end else begin
								ctl.wr_front = (cmd == oli_pkg::CMD_PUSH_FRONT);
								ctl.wr_back  = (cmd == oli_pkg::CMD_PUSH_BACK);
							end
						end
						oli_pkg::CMD_DELETE: begin
							if (sts.empty) begin
								ctl.emit   = 1'b1;
								ctl.last   = 1'b1;
								ctl.status = oli_pkg::ST_NOT_FOUND;
							end else begin
								ctl.load = 1'b1;
								state_d  = S_DEL;
							end
						end
						default: begin
							if (sts.empty) begin
								ctl.emit   = 1'b1;
								ctl.last   = 1'b1;
								ctl.status = oli_pkg::ST_EMPTY;
							end else begin
								ctl.load = 1'b1;
								state_d  = S_DUMP;
							end
						end
					endcase
				end
			end
			S_DEL: begin
				ctl.rd   = !sts.issue_done;
				ctl.step = sts.pv;
				if (sts.pv && sts.plast) begin
					ctl.commit = sts.found;
					ctl.emit   = 1'b1;
					ctl.last   = 1'b1;
					ctl.status = sts.found ? oli_pkg::ST_OK : oli_pkg::ST_NOT_FOUND;
					state_d    = S_IDLE;
				end
			end
			S_DUMP: begin
				ctl.rd = !sts.issue_done;
				if (sts.pv) begin
					ctl.emit     = 1'b1;
					ctl.item_sel = 1'b1;
					ctl.last     = sts.plast;
					if (sts.plast) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= ctl.emit;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> src/oli_dp.sv
// Datapath for the ordered list block: ring buffer pointers, scan and result registers.
module oli_dp #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oli_pkg::ctl_t      ctl,
	input  logic signed [31:0] value,
	output oli_pkg::sts_t      sts,
	output logic [1:0]         status,
	output logic signed [31:0] item,
	output logic [6:0]         entry_count,
	output logic               last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pidx_q;
	logic [CW-1:0] hole_q;
	logic          pv_q;
	logic          found_q;
	logic [31:0]   key_q;

	logic [AW-1:0] front_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [31:0]   rdata;
	logic          match;

	// Physical slot of a logical position, counted from the head.
	function automatic logic [AW-1:0] phys(input logic [CW-1:0] j);
		logic [CW:0] s;
		s = (CW+1)'(head_q) + (CW+1)'(j);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return AW'(s);
	endfunction

	assign front_addr = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign match      = (rdata == key_q);

	always_comb begin
		we    = ctl.wr_front | ctl.wr_back | (ctl.step & found_q);
		waddr = phys(hole_q);
		wdata = rdata;
		if (ctl.wr_front) begin
			waddr = front_addr;
			wdata = value;
		end else if (ctl.wr_back) begin
			waddr = phys(count_q);
			wdata = value;
		end
	end

	always_comb begin
		count_d = count_q;
		if (ctl.wr_front || ctl.wr_back) begin
			count_d = count_q + CW'(1);
		end else if (ctl.commit) begin
			count_d = count_q - CW'(1);
		end
	end

	oli_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd),
		.raddr(phys(idx_q)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pidx_q  <= '0;
			hole_q  <= '0;
			pv_q    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			count_q <= count_d;
			pv_q    <= ctl.rd;
			if (ctl.wr_front) begin
				head_q <= front_addr;
			end
			if (ctl.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (ctl.rd) begin
				idx_q  <= idx_q + CW'(1);
				pidx_q <= idx_q;
			end
			if (ctl.step) begin
				if (found_q || match) begin
					found_q <= 1'b1;
					hole_q  <= pidx_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= value;
		end
		if (ctl.emit) begin
			status      <= ctl.status;
			item        <= ctl.item_sel ? rdata : '0;
			entry_count <= 7'(count_d);
			last        <= ctl.last;
		end
	end

	assign sts.full       = (count_q == CW'(DEPTH));
	assign sts.empty      = (count_q == '0);
	assign sts.issue_done = (idx_q == count_q);
	assign sts.pv         = pv_q;
	assign sts.plast      = (pidx_q == count_q - CW'(1));
	assign sts.found      = found_q | match;

endmodule

>>> src/ordered_list_insert_delete.sv
// Push front and push back write the RAM at acceptance: the result word shows in the cycle after.
// Delete scans the list through the RAM read port, one entry per cycle, closing the gap as it goes;
// its result shows once the back entry has been read, and busy stays high meanwhile.
// Dump emits one word per cycle, from the front of the list to the back.
// Reset clears the entry count and the ring pointers; list storage is left as it was.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module ordered_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               busy,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic signed [31:0] item,
	output logic [6:0]         entry_count,
	output logic               last
);

	// The list lives in a ring buffer held in a RAM. The head pointer marks the
	// front entry, so a push at either end is a single write with no shifting.
	// A delete walks the list from the front; once the matching word is found,
	// every later word is written one slot toward the front as it is read back.
	// The controller only sequences; pointers, scan index and result registers
	// all sit in the datapath.

	oli_pkg::ctl_t ctl;
	oli_pkg::sts_t sts;

	oli_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (oli_pkg::cmd_t'(cmd)),
		.sts         (sts),
		.ctl         (ctl),
		.busy        (busy),
		.result_valid(result_valid)
	);

	oli_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.value      (value),
		.sts        (sts),
		.status     (status),
		.item       (item),
		.entry_count(entry_count),
		.last       (last)
	);

endmodule

>>> src/oli_chk.sv
// Port-level checker for the ordered list block, bound to the top level.
module oli_chk #(
	parameter int DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic [1:0]         cmd,
	input logic signed [31:0] value,
	input logic               busy,
	input logic               result_valid,
	input logic [1:0]         status,
	input logic signed [31:0] item,
	input logic [6:0]         entry_count,
	input logic               last
);

	// A push answers with a single final word in the very next cycle.
	a_push_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == oli_pkg::CMD_PUSH_FRONT || cmd == oli_pkg::CMD_PUSH_BACK))
		|=> (result_valid && last && item == 0))
		else $error("push did not answer with one final word");

	// Error statuses always come as a lone final word with no item.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != oli_pkg::ST_OK) |-> (last && item == 0))
		else $error("error status word is not a lone final word");

	// An empty dump reports a count of zero.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == oli_pkg::ST_EMPTY) |-> (entry_count == 0))
		else $error("empty status with nonzero entry count");

	// The reported count never exceeds the list capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (entry_count <= 7'(DEPTH)))
		else $error("entry count beyond capacity");

endmodule

bind ordered_list_insert_delete oli_chk #(.DEPTH(DEPTH)) u_chk (.*);
